/* hw/rtl/sorted_hash_set_assert.svh */
// ----------------------------------------------------------------------------
// sorted_hash_set assertion macros
// concurrent checks clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef SORTED_HASH_SET_ASSERT_SVH
`define SORTED_HASH_SET_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SHS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SHS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hw/rtl/shs_pkg.sv */
// ----------------------------------------------------------------------------
// shs_pkg
// shared types and codes of the sorted key set
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shs_pkg;

    localparam int KEY_W    = 32;
    localparam int ACTION_W = 2;
    localparam int ECOUNT_W = 7;

    typedef logic [ACTION_W-1:0] action_t;

    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_QUERY  = 2'd1;
    localparam action_t ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic load;
        logic rd_mid;
        logic cmp;
        logic shift_rd;
        logic shift_wr;
        logic write_key;
        logic refuse;
        logic emit;
    } shs_cmd_t;

    typedef struct packed {
        logic search_open;
        logic found;
        logic is_insert;
        logic full;
        logic shift_done;
    } shs_status_t;

endpackage

/* hw/rtl/sorted_hash_set.sv */
// ----------------------------------------------------------------------------
// sorted_hash_set
// ordered set of 32-bit keys with binary search, insert, query and clear
//
// channel | direction | signals
// --------+-----------+-----------------------------------------------------
// s_      | in        | s_valid s_ready s_action s_key_hash
// m_      | out       | m_valid m_ready m_present m_inserted m_full_refused
//         |           | m_entry_count
//
// one item at a time; a probe of the search is a registered read of the
// key memory and a compare; a search makes about log2(count + 1) probes
// insert of a new key first moves the keys from its position up one slot,
// a read and a write per key; clear or an unused code skips the search
// reset zeroes count, control state and m_valid; no memory clearing pass
// a finished result waits in the output register; the next item is taken
// meanwhile, and only the handoff of its own result stalls on m_ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sorted_hash_set_assert.svh"

module sorted_hash_set
    import shs_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [KEY_W-1:0]    s_key_hash,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_present,
    output logic                m_inserted,
    output logic                m_full_refused,
    output logic [ECOUNT_W-1:0] m_entry_count
);

    shs_cmd_t    cmd;
    shs_status_t status;

    shs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    shs_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_action       (s_action),
        .s_key_hash     (s_key_hash),
        .status         (status),
        .m_present      (m_present),
        .m_inserted     (m_inserted),
        .m_full_refused (m_full_refused),
        .m_entry_count  (m_entry_count)
    );

    // outcome flags are mutually exclusive
    `SHS_ASSERT_IMPLY(a_ins_fresh, m_valid && m_inserted, !m_present, "inserted key was present")
    `SHS_ASSERT_IMPLY(a_ins_room, m_valid && m_inserted, !m_full_refused, "inserted and refused")

    // an accepted item leaves the idle state
    `SHS_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready held after accept")

    // an emitted item always shows up on the result channel
    `SHS_ASSERT_NEXT(a_emit_valid, cmd.emit, m_valid, "emitted item not valid")

    // the shift loop runs only when room remains
    `SHS_ASSERT_IMPLY(a_shift_room, cmd.write_key, !status.full, "write into full store")

endmodule

/* hw/rtl/shs_datapath.sv */
// ----------------------------------------------------------------------------
// shs_datapath
// key store, search bounds, shift pointer, count and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shs_datapath
    import shs_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  shs_cmd_t            cmd,
    input  action_t             s_action,
    input  logic [KEY_W-1:0]    s_key_hash,
    output shs_status_t         status,
    output logic                m_present,
    output logic                m_inserted,
    output logic                m_full_refused,
    output logic [ECOUNT_W-1:0] m_entry_count
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic [KEY_W-1:0] mem [CAPACITY];

    logic [KEY_W-1:0] rdata_reg;
    logic [KEY_W-1:0] key_reg;
    action_t          act_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             found_reg, found_next;
    logic             inserted_reg, inserted_next;
    logic             refused_reg, refused_next;

    logic             present_reg;
    logic             out_ins_reg;
    logic             out_ref_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  ptr_m1;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;
    logic              wr_en;

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign ptr_m1 = ptr_reg - CNT_W'(1);

    always_comb begin
        rd_en   = cmd.rd_mid | cmd.shift_rd;
        rd_addr = cmd.rd_mid ? mid[ADDR_W-1:0] : ptr_m1[ADDR_W-1:0];
        wr_en   = cmd.shift_wr | cmd.write_key;
        wr_addr = cmd.shift_wr ? ptr_reg[ADDR_W-1:0] : lo_reg[ADDR_W-1:0];
        wr_data = cmd.shift_wr ? rdata_reg : key_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        ptr_next      = ptr_reg;
        found_next    = found_reg;
        inserted_next = inserted_reg;
        refused_next  = refused_reg;
        if (cmd.load) begin
            lo_next       = '0;
            hi_next       = count_reg;
            ptr_next      = count_reg;
            found_next    = 1'b0;
            inserted_next = 1'b0;
            refused_next  = 1'b0;
            if (s_action == ACT_CLEAR) begin
                count_next = '0;
            end
        end
        if (cmd.cmp) begin
            if (rdata_reg < key_reg) begin
                lo_next = mid_reg + CNT_W'(1);
            end else begin
                hi_next = mid_reg;
            end
            if (rdata_reg == key_reg) begin
                found_next = 1'b1;
            end
        end
        if (cmd.shift_wr) begin
            ptr_next = ptr_m1;
        end
        if (cmd.write_key) begin
            count_next    = count_reg + CNT_W'(1);
            inserted_next = 1'b1;
        end
        if (cmd.refuse) begin
            refused_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        ptr_reg      <= ptr_next;
        found_reg    <= found_next;
        inserted_reg <= inserted_next;
        refused_reg  <= refused_next;
        if (cmd.load) begin
            key_reg <= s_key_hash;
            act_reg <= s_action;
        end
        if (cmd.rd_mid) begin
            mid_reg <= mid;
        end
        if (cmd.emit) begin
            present_reg <= found_reg;
            out_ins_reg <= inserted_reg;
            out_ref_reg <= refused_reg;
            out_cnt_reg <= count_reg;
        end
    end

    always_comb begin
        status.search_open = (lo_reg < hi_reg);
        status.found       = found_reg;
        status.is_insert   = (act_reg == ACT_INSERT);
        status.full        = (count_reg == CNT_W'(CAPACITY));
        status.shift_done  = (ptr_reg == lo_reg);
    end

    assign m_present      = present_reg;
    assign m_inserted     = out_ins_reg;
    assign m_full_refused = out_ref_reg;
    assign m_entry_count  = ECOUNT_W'(out_cnt_reg);

endmodule

/* hw/rtl/shs_ctrl.sv */
// ----------------------------------------------------------------------------
// shs_ctrl
// request sequencer: binary search probes, shift-up loop, result handoff
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shs_ctrl
    import shs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  action_t     s_action,
    output logic        m_valid,
    input  logic        m_ready,
    input  shs_status_t status,
    output shs_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_PROBE    = 8'b0000_0010,
        ST_COMPARE  = 8'b0000_0100,
        ST_DECIDE   = 8'b0000_1000,
        ST_SHIFT_RD = 8'b0001_0000,
        ST_SHIFT_WR = 8'b0010_0000,
        ST_WRITE    = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_action == ACT_INSERT || s_action == ACT_QUERY) begin
                        state_next = ST_PROBE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_PROBE: begin
                if (status.search_open) begin
                    cmd.rd_mid = 1'b1;
                    state_next = ST_COMPARE;
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_COMPARE: begin
                cmd.cmp    = 1'b1;
                state_next = ST_PROBE;
            end
            ST_DECIDE: begin
                if (!status.is_insert || status.found) begin
                    state_next = ST_DONE;
                end else if (status.full) begin
                    cmd.refuse = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD: begin
                if (status.shift_done) begin
                    state_next = ST_WRITE;
                end else begin
                    cmd.shift_rd = 1'b1;
                    state_next   = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = ST_SHIFT_RD;
            end
            ST_WRITE: begin
                cmd.write_key = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule
